// ----- rtl/core/brbs_pkg.sv -----
// ----------------------------------------------------------------------------
// brbs_pkg
// shared types and constants for the byte ring buffer with search
// ----------------------------------------------------------------------------
`default_nettype none

package brbs_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int CAP_W     = 9;
    localparam int CNT_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 8;
    localparam int CAP_RESET = 256;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH        = 3'd0,
        FN_POP         = 3'd1,
        FN_PEEK_LAST   = 3'd2,
        FN_REMOVE_LAST = 3'd3,
        FN_FIND        = 3'd4,
        FN_CLEAR       = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FIND
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/byte_ring_buffer_with_search.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_search
// byte ring buffer with programmable capacity and a linear search sequencer
// ----------------------------------------------------------------------------
// push, remove last, clear and refused operations give their result in the cycle
//   after acceptance; pop and peek last pass through the read state (registered ram read)
// find reads one stored byte per cycle, in order from the head, through the
//   single ram read port, compared by one byte comparator; a new item is taken
//   once the result is out or being taken
// reset: ring empty, both pointers 0, capacity min(256, DEPTH); storage not cleared
`default_nettype none

module byte_ring_buffer_with_search #(
    parameter int DEPTH = brbs_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [brbs_pkg::CAP_W-1:0]    capacity,
    // input items
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [brbs_pkg::FUNC_W-1:0]   func,
    input  wire logic [brbs_pkg::BYTE_W-1:0]   data_byte,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               ok,
    output logic      [brbs_pkg::BYTE_W-1:0]   read_byte,
    output logic      [brbs_pkg::POS_W-1:0]    position,
    output logic      [brbs_pkg::CNT_W-1:0]    fill_count
);

    localparam int CAP_W  = brbs_pkg::CAP_W;
    localparam int CNT_W  = brbs_pkg::CNT_W;
    localparam int BYTE_W = brbs_pkg::BYTE_W;
    localparam int POS_W  = brbs_pkg::POS_W;
    localparam logic [CAP_W-1:0] CAP_RST =
        CAP_W'((DEPTH < brbs_pkg::CAP_RESET) ? DEPTH : brbs_pkg::CAP_RESET);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] i,
                                              input logic [CAP_W-1:0] c);
        logic [31:0] s;
        begin
            s = 32'(i) + 32'd1;
            return (s >= 32'(c)) ? '0 : AW'(s);
        end
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] i,
                                              input logic [CAP_W-1:0] c);
        return (i == '0) ? AW'(32'(c) - 32'd1) : i - AW'(1);
    endfunction

    brbs_pkg::state_t st_reg, st_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] key_reg, key_next;
    logic              out_valid_reg, out_valid_next;
    logic              ok_reg;
    logic [BYTE_W-1:0] read_byte_reg;
    logic [POS_W-1:0]  position_reg;
    logic [CNT_W-1:0]  fill_count_reg;

    logic              load;
    logic              ok_n;
    logic [BYTE_W-1:0] rd_n;
    logic [POS_W-1:0]  pos_n;
    logic              in_fire;
    logic              cfg_fire;
    logic [CAP_W-1:0]  cap_sat;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    brbs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (st_reg == brbs_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign cfg_ready = (st_reg == brbs_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // capacity zero becomes one, anything beyond the storage becomes DEPTH
    always_comb
    begin
        priority if (capacity == '0)
        begin
            cap_sat = CAP_W'(1);
        end
        else if (32'(capacity) > 32'(DEPTH))
        begin
            cap_sat = CAP_W'(DEPTH);
        end
        else
        begin
            cap_sat = capacity;
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        cap_next   = cap_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        ram_wdata  = data_byte;
        ram_raddr  = scan_reg;
        load       = 1'b0;
        ok_n       = 1'b0;
        rd_n       = '0;
        pos_n      = '0;

        unique case (st_reg)
            brbs_pkg::ST_IDLE:
            begin
                unique case (func)
                    brbs_pkg::FN_PEEK_LAST: ram_raddr = ptr_dec(tail_reg, cap_reg);
                    default:                ram_raddr = head_reg;
                endcase
                if (in_fire)
                begin
                    unique case (func)
                        brbs_pkg::FN_PUSH:
                        begin
                            load = 1'b1;
                            if (32'(count_reg) < 32'(cap_reg))
                            begin
                                ram_we     = 1'b1;
                                tail_next  = ptr_inc(tail_reg, cap_reg);
                                count_next = count_reg + CNT_W'(1);
                                ok_n       = 1'b1;
                            end
                        end
                        brbs_pkg::FN_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = ptr_inc(head_reg, cap_reg);
                                count_next = count_reg - CNT_W'(1);
                                st_next    = brbs_pkg::ST_READ;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        brbs_pkg::FN_PEEK_LAST:
                        begin
                            if (count_reg != '0)
                            begin
                                st_next = brbs_pkg::ST_READ;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        brbs_pkg::FN_REMOVE_LAST:
                        begin
                            load = 1'b1;
                            if (count_reg != '0)
                            begin
                                tail_next  = ptr_dec(tail_reg, cap_reg);
                                count_next = count_reg - CNT_W'(1);
                                ok_n       = 1'b1;
                            end
                        end
                        brbs_pkg::FN_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                scan_next = ptr_inc(head_reg, cap_reg);
                                idx_next  = '0;
                                key_next  = data_byte;
                                st_next   = brbs_pkg::ST_FIND;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        brbs_pkg::FN_CLEAR:
                        begin
                            load       = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            ok_n       = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
                if (cfg_fire)
                begin
                    cap_next   = cap_sat;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
            end
            brbs_pkg::ST_READ:
            begin
                load    = 1'b1;
                ok_n    = 1'b1;
                rd_n    = ram_rdata;
                st_next = brbs_pkg::ST_IDLE;
            end
            brbs_pkg::ST_FIND:
            begin
                // ram data belongs to entry idx_reg, next address already issued
                scan_next = ptr_inc(scan_reg, cap_reg);
                idx_next  = idx_reg + CNT_W'(1);
                priority if (ram_rdata == key_reg)
                begin
                    load    = 1'b1;
                    ok_n    = 1'b1;
                    pos_n   = POS_W'(idx_reg);
                    st_next = brbs_pkg::ST_IDLE;
                end
                else if (idx_next == count_reg)
                begin
                    load    = 1'b1;
                    st_next = brbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = brbs_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= brbs_pkg::ST_IDLE;
            cap_reg       <= CAP_RST;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (load)
        begin
            ok_reg         <= ok_n;
            read_byte_reg  <= rd_n;
            position_reg   <= pos_n;
            fill_count_reg <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign read_byte  = read_byte_reg;
    assign position   = position_reg;
    assign fill_count = fill_count_reg;

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(cap_reg))
        else $error("fill count above capacity");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(head_reg) < 32'(cap_reg)) && (32'(tail_reg) < 32'(cap_reg)))
        else $error("pointer outside ring");

    a_find_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == brbs_pkg::ST_FIND) |-> (idx_reg < count_reg))
        else $error("search ran past stored bytes");

    a_busy_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != brbs_pkg::ST_IDLE) |-> !out_valid_reg)
        else $error("result slot occupied while busy");

endmodule

`default_nettype wire

// ----- rtl/core/brbs_ram.sv -----
// ----------------------------------------------------------------------------
// brbs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module brbs_ram #(
    parameter int WIDTH = brbs_pkg::BYTE_W,
    parameter int DEPTH = brbs_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the byte ring buffer with search: a queue-fed driver
// offers operations, a monitor checks every result against a local ring model
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP_W  = brbs_pkg::CAP_W;
    localparam int CNT_W  = brbs_pkg::CNT_W;
    localparam int BYTE_W = brbs_pkg::BYTE_W;
    localparam int FUNC_W = brbs_pkg::FUNC_W;
    localparam int POS_W  = brbs_pkg::POS_W;

    // func codes the block treats as no operation
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
    localparam int RING_MAX = 256;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [BYTE_W-1:0] arg;
    } ring_op_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] rd;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  fill;
    } ring_result_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [CAP_W-1:0]    capacity   = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func       = '0;
    logic [BYTE_W-1:0]   data_byte  = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                ok;
    logic [BYTE_W-1:0]   read_byte;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    fill_count;

    ring_op_t     pending_ops[$];
    ring_result_t expected_results[$];

    // local copy of the ring
    logic [BYTE_W-1:0] ring_mem [RING_MAX];
    int                ring_head = 0;
    int                ring_tail = 0;
    int                ring_cnt  = 0;
    logic [CAP_W-1:0]  ring_cap  = CAP_W'(brbs_pkg::CAP_RESET);

    bit idle_en     = 1'b1;
    int in_gap      = 0;
    int rx_gap      = 0;
    int rx_hold_len = 0;
    int error_count = 0;

    byte_ring_buffer_with_search u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_byte  (read_byte),
        .position   (position),
        .fill_count (fill_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int ring_wrap_next(int i, int c);
        return (i + 1 >= c) ? 0 : i + 1;
    endfunction

    function automatic void ring_configure(logic [CAP_W-1:0] v);
        ring_cap  = v;
        ring_head = 0;
        ring_tail = 0;
        ring_cnt  = 0;
    endfunction

    // apply one operation to the local ring and queue the result it gives
    function automatic void ring_step(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] d);
        ring_result_t r;
        int           c;
        int           a;
        r = '0;
        c = int'(ring_cap);
        if (c == 0)
            c = 1;
        if (c > RING_MAX)
            c = RING_MAX;
        if (ring_head >= c)
            ring_head = 0;
        if (ring_tail >= c)
            ring_tail = 0;
        if (ring_cnt > c)
            ring_cnt = c;
        unique case (f)
            brbs_pkg::FN_PUSH:
            begin
                if (ring_cnt < c)
                begin
                    ring_mem[ring_tail] = d;
                    ring_tail = ring_wrap_next(ring_tail, c);
                    ring_cnt++;
                    r.ok = 1'b1;
                end
            end
            brbs_pkg::FN_POP:
            begin
                if (ring_cnt != 0)
                begin
                    r.rd = ring_mem[ring_head];
                    ring_head = ring_wrap_next(ring_head, c);
                    ring_cnt--;
                    r.ok = 1'b1;
                end
            end
            brbs_pkg::FN_PEEK_LAST:
            begin
                if (ring_cnt != 0)
                begin
                    r.rd = ring_mem[(ring_tail == 0) ? c - 1 : ring_tail - 1];
                    r.ok = 1'b1;
                end
            end
            brbs_pkg::FN_REMOVE_LAST:
            begin
                if (ring_cnt != 0)
                begin
                    ring_tail = (ring_tail == 0) ? c - 1 : ring_tail - 1;
                    ring_cnt--;
                    r.ok = 1'b1;
                end
            end
            brbs_pkg::FN_FIND:
            begin
                a = ring_head;
                for (int i = 0; i < ring_cnt; i++)
                begin
                    if (ring_mem[a] == d)
                    begin
                        r.ok  = 1'b1;
                        r.pos = i[POS_W-1:0];
                        break;
                    end
                    a = ring_wrap_next(a, c);
                end
            end
            brbs_pkg::FN_CLEAR:
            begin
                ring_head = 0;
                ring_tail = 0;
                ring_cnt  = 0;
                r.ok      = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.fill = ring_cnt[CNT_W-1:0];
        expected_results.push_back(r);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // driver: offers queued items, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin : op_driver
        ring_op_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                ring_step(func, data_byte);
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    nxt = pending_ops.pop_front();
                    in_valid  <= 1'b1;
                    func      <= nxt.op;
                    data_byte <= nxt.arg;
                    if (idle_en && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 13);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes result items and checks them in order
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        ring_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("unexpected item", int'(fill_count), -1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (ok !== want.ok)
                        flag_mismatch("ok", int'(ok), int'(want.ok));
                    if (read_byte !== want.rd)
                        flag_mismatch("read_byte", int'(read_byte), int'(want.rd));
                    if (position !== want.pos)
                        flag_mismatch("position", int'(position), int'(want.pos));
                    if (fill_count !== want.fill)
                        flag_mismatch("fill_count", int'(fill_count), int'(want.fill));
                end
            end
            if (rx_hold_len > 0)
            begin
                rx_hold_len--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 9) == 0)
                    rx_gap = $urandom_range(1, 13);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        unique case ($urandom_range(0, 3))
            0:       return BYTE_W'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_op(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] d);
        ring_op_t o;
        o.op  = f;
        o.arg = d;
        pending_ops.push_back(o);
    endfunction

    function automatic void queue_random_op(int push_w);
        int s;
        if ($urandom_range(0, 99) < push_w)
        begin
            queue_op(brbs_pkg::FN_PUSH, pick_byte());
        end
        else
        begin
            s = $urandom_range(0, 99);
            if (s < 35)
                queue_op(brbs_pkg::FN_POP, pick_byte());
            else if (s < 50)
                queue_op(brbs_pkg::FN_PEEK_LAST, pick_byte());
            else if (s < 65)
                queue_op(brbs_pkg::FN_REMOVE_LAST, pick_byte());
            else if (s < 90)
                queue_op(brbs_pkg::FN_FIND, pick_byte());
            else if (s < 95)
                queue_op(brbs_pkg::FN_CLEAR, pick_byte());
            else
                queue_op($urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO, pick_byte());
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        capacity  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_configure(v);
    endtask

    task automatic run_random(logic [CAP_W-1:0] cap_val, int n_items, int push_w);
        set_capacity(cap_val);
        @(negedge clk);
        repeat (n_items)
            queue_random_op(push_w);
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, at the capacity left by reset
        queue_op(brbs_pkg::FN_PUSH, 8'h00);
        queue_op(brbs_pkg::FN_PUSH, 8'hFF);
        queue_op(brbs_pkg::FN_PEEK_LAST, 8'h00);
        queue_op(brbs_pkg::FN_FIND, 8'hFF);
        queue_op(brbs_pkg::FN_FIND, 8'h5A);
        queue_op(brbs_pkg::FN_REMOVE_LAST, 8'h00);
        queue_op(brbs_pkg::FN_POP, 8'h00);
        queue_op(brbs_pkg::FN_POP, 8'h00);
        queue_op(brbs_pkg::FN_PEEK_LAST, 8'h00);
        queue_op(brbs_pkg::FN_REMOVE_LAST, 8'h00);
        queue_op(brbs_pkg::FN_FIND, 8'h00);
        queue_op(FN_SPARE_LO, 8'hFF);
        queue_op(FN_SPARE_HI, 8'h00);
        queue_op(brbs_pkg::FN_PUSH, 8'h80);
        queue_op(brbs_pkg::FN_CLEAR, 8'h00);
        wait_drained();

        // single-entry ring: second push is refused
        set_capacity(9'd1);
        @(negedge clk);
        queue_op(brbs_pkg::FN_PUSH, 8'h7F);
        queue_op(brbs_pkg::FN_PUSH, 8'h01);
        queue_op(brbs_pkg::FN_FIND, 8'h7F);
        queue_op(brbs_pkg::FN_POP, 8'h00);
        wait_drained();

        // zero capacity behaves as one
        set_capacity(9'd0);
        @(negedge clk);
        queue_op(brbs_pkg::FN_PUSH, 8'hAA);
        queue_op(brbs_pkg::FN_PUSH, 8'h55);
        queue_op(brbs_pkg::FN_PEEK_LAST, 8'h00);
        wait_drained();

        // oversize capacity saturates
        set_capacity(9'h1FF);
        @(negedge clk);
        queue_op(brbs_pkg::FN_PUSH, 8'h11);
        queue_op(brbs_pkg::FN_FIND, 8'h11);
        queue_op(brbs_pkg::FN_CLEAR, 8'h00);
        wait_drained();

        // small ring with a long receiver stall so the input backs up
        set_capacity(CAP_W'($urandom_range(2, 16)));
        @(negedge clk);
        rx_hold_len = 300;
        repeat (250)
            queue_random_op(45);
        wait_drained();

        // full size, push heavy so it fills up and finds walk far; then random capacities
        run_random(9'd256, 300, 88);
        run_random(CAP_W'($urandom_range(17, 255)), 200, 50);
        run_random(CAP_W'($urandom_range(1, 3)), 150, 45);
        run_random(CAP_W'($urandom_range(257, 511)), 80, 60);

        // last part with no idling
        idle_en = 1'b0;
        in_gap  = 0;
        rx_gap  = 0;
        run_random(CAP_W'($urandom_range(1, 64)), 150, 50);

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch("items still expected", 0, expected_results.size());
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
